[rtl/cdgs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cyclic dominance grid spread: shared package
// Grid dimensions, field widths, type and command codes, the controller to
// datapath command and status structs, and the dominance helper functions.
// ----------------------------------------------------------------------------
package cdgs_pkg;

  // Grid storage dimensions.
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int X_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Y_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XC_W   = $clog2(MAX_WIDTH + 1);
  localparam int YC_W   = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Fixed field widths.
  localparam int POS_W     = 7;
  localparam int CFG_W     = 8;
  localparam int TYPE_W    = 2;
  localparam int DIR_W     = 2;
  localparam int ENTRY_W   = 4;
  localparam int CFG_IDX_W = 1;

  // Common widths for comparing port positions against the grid size.
  localparam int CX_W = (XC_W > POS_W) ? XC_W : POS_W;
  localparam int CY_W = (YC_W > POS_W) ? YC_W : POS_W;

  // Layout of one grid entry: type in the low bits, then lock and stamp.
  localparam int ENT_LOCK  = 2;
  localparam int ENT_STAMP = 3;

  localparam logic [CFG_W-1:0] GRID_SIZE_RESET = CFG_W'(100);

  // Cell types.
  localparam logic [TYPE_W-1:0] TYPE_EMPTY  = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_NORMAL = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_IMMUNE = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_TOXIC  = 2'd3;

  // Spread directions.
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

  // Item kinds.
  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_VISIT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;  // write one cleared entry of the clearing pass
    logic start;     // take the transaction and read its cell
    logic eval;      // act on the cell just read
    logic spread;    // act on the neighbour just read
    logic finish;    // load the result register
  } cdgs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;     // clearing pass is at its last entry
    logic need_spread;  // visited cell will try to take its neighbour
    logic out_busy;     // result register is full and not being taken
  } cdgs_stat_t;

  // True if attacker type a conquers defender type d.
  function automatic logic beats(logic [TYPE_W-1:0] a, logic [TYPE_W-1:0] d);
    return (a == TYPE_TOXIC  && d == TYPE_NORMAL) ||
           (a == TYPE_IMMUNE && d == TYPE_TOXIC)  ||
           (a == TYPE_NORMAL && d == TYPE_IMMUNE);
  endfunction

  // An empty cell is always taken; an occupied one only if beaten.
  function automatic logic can_take(logic [TYPE_W-1:0] a, logic [TYPE_W-1:0] d);
    return (d == TYPE_EMPTY) || beats(a, d);
  endfunction

  // Row-major address of a cell.
  function automatic logic [ADDR_W-1:0] cell_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y);
    logic [31:0] a;
    a = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
    return a[ADDR_W-1:0];
  endfunction

  // Effective column count: zero reads as one, too large as the maximum.
  function automatic logic [XC_W-1:0] eff_width(logic [CFG_W-1:0] v);
    logic [XC_W-1:0] r;
    if (v == '0) begin
      r = XC_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      r = XC_W'(MAX_WIDTH);
    end else begin
      r = XC_W'(v);
    end
    return r;
  endfunction

  // Effective row count, clamped the same way.
  function automatic logic [YC_W-1:0] eff_height(logic [CFG_W-1:0] v);
    logic [YC_W-1:0] r;
    if (v == '0) begin
      r = YC_W'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      r = YC_W'(MAX_HEIGHT);
    end else begin
      r = YC_W'(v);
    end
    return r;
  endfunction

endpackage

[rtl/cyclic_dominance_grid_spread.sv]
`timescale 1ns / 1ps
// Result: registered from the evaluate state, or from the spread state for a visit
//   whose cell tries to take its neighbour; a full result register holds it back.
// Flow: no new transaction is taken until the last one is finished; the grid
//   memory's one read port is used for the cell and then its neighbour.
// Reset: a clearing pass writes all 16384 grid entries, one per cycle, with
//   in_ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// Cyclic dominance grid spread: top level
// Toroidal rock-paper-scissors grid with place and raster-order visit
// transactions, lazy lock clearing by sweep parity.
// ----------------------------------------------------------------------------
module cyclic_dominance_grid_spread (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cdgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdgs_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [cdgs_pkg::POS_W-1:0]      in_pos_x,
  input  logic [cdgs_pkg::POS_W-1:0]      in_pos_y,
  input  logic [cdgs_pkg::TYPE_W-1:0]     in_seed_type,
  input  logic [cdgs_pkg::DIR_W-1:0]      in_direction,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cdgs_pkg::POS_W-1:0]      out_cell_x,
  output logic [cdgs_pkg::POS_W-1:0]      out_cell_y,
  output logic [cdgs_pkg::TYPE_W-1:0]     out_cell_type,
  output logic                            out_conquered,
  output logic                            out_sweep_done
);
  import cdgs_pkg::*;

  cdgs_cmd_t  cmd;
  cdgs_stat_t stat;

  // Size registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  cdgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdgs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_kind        (in_kind),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_seed_type   (in_seed_type),
    .in_direction   (in_direction),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_x     (out_cell_x),
    .out_cell_y     (out_cell_y),
    .out_cell_type  (out_cell_type),
    .out_conquered  (out_conquered),
    .out_sweep_done (out_sweep_done)
  );

endmodule

[rtl/cdgs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cyclic dominance grid spread: controller
// Sequences the clearing pass after reset and the memory phases of each
// transaction: cell read, cell update with neighbour read, neighbour update.
// ----------------------------------------------------------------------------
module cdgs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cdgs_pkg::cdgs_stat_t  stat,
  output cdgs_pkg::cdgs_cmd_t   cmd
);
  import cdgs_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_SPREAD
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        // A spreading visit updates its cell at once; the result comes later.
        if (stat.need_spread) begin
          cmd.eval  = 1'b1;
          state_nxt = S_SPREAD;
        end else if (!stat.out_busy) begin
          cmd.eval   = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SPREAD: begin
        if (!stat.out_busy) begin
          cmd.spread = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/cdgs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cyclic dominance grid spread: datapath
// Holds the grid memory, size registers, scan position and sweep parity,
// the transaction registers and the result register.
// ----------------------------------------------------------------------------
module cdgs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cdgs_pkg::cdgs_cmd_t                 cmd,
  output cdgs_pkg::cdgs_stat_t                stat,
  input  logic                                cfg_valid,
  input  logic [cdgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cdgs_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_kind,
  input  logic [cdgs_pkg::POS_W-1:0]          in_pos_x,
  input  logic [cdgs_pkg::POS_W-1:0]          in_pos_y,
  input  logic [cdgs_pkg::TYPE_W-1:0]         in_seed_type,
  input  logic [cdgs_pkg::DIR_W-1:0]          in_direction,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cdgs_pkg::POS_W-1:0]          out_cell_x,
  output logic [cdgs_pkg::POS_W-1:0]          out_cell_y,
  output logic [cdgs_pkg::TYPE_W-1:0]         out_cell_type,
  output logic                                out_conquered,
  output logic                                out_sweep_done
);
  import cdgs_pkg::*;

  // Size registers.
  logic [CFG_W-1:0] grid_width_r, grid_height_r;
  logic [XC_W-1:0]  w;
  logic [YC_W-1:0]  h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_SIZE_RESET;
      grid_height_r <= GRID_SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        REG_GRID_HEIGHT: grid_height_r <= cfg_data;
      endcase
    end
  end

  assign w = eff_width(grid_width_r);
  assign h = eff_height(grid_height_r);

  // Scan position of the next visit and the sweep parity.
  logic [X_W-1:0]  scan_x_r;
  logic [Y_W-1:0]  scan_y_r;
  logic            parity_r;

  // Visit position after wrapping a scan position left outside the grid.
  logic            wrap_x, wrap_y;
  logic [YC_W-1:0] y_a;
  logic [X_W-1:0]  cx;
  logic [Y_W-1:0]  cy;
  logic            par;
  logic [XC_W-1:0] adv_x;
  logic [YC_W-1:0] adv_y;
  logic            row_end, grid_end;
  logic [X_W-1:0]  nscan_x;
  logic [Y_W-1:0]  nscan_y;

  always_comb begin
    wrap_x   = XC_W'(scan_x_r) >= w;
    y_a      = YC_W'(scan_y_r) + YC_W'(wrap_x);
    wrap_y   = y_a >= h;
    cx       = (wrap_x || wrap_y) ? '0 : scan_x_r;
    cy       = wrap_y ? '0 : y_a[Y_W-1:0];
    par      = parity_r ^ wrap_y;
    adv_x    = XC_W'(cx) + XC_W'(1);
    adv_y    = YC_W'(cy) + YC_W'(1);
    row_end  = adv_x >= w;
    grid_end = row_end && (adv_y >= h);
    nscan_x  = row_end ? '0 : adv_x[X_W-1:0];
    if (grid_end) begin
      nscan_y = '0;
    end else if (row_end) begin
      nscan_y = adv_y[Y_W-1:0];
    end else begin
      nscan_y = cy;
    end
  end

  // Placement position and its bounds check.
  logic            in_grid;
  logic [X_W-1:0]  px;
  logic [Y_W-1:0]  py;
  logic [ADDR_W-1:0] start_addr;

  assign in_grid    = (CX_W'(in_pos_x) < CX_W'(w)) && (CY_W'(in_pos_y) < CY_W'(h));
  assign px         = X_W'(in_pos_x);
  assign py         = Y_W'(in_pos_y);
  assign start_addr = (in_kind == KIND_VISIT) ? cell_addr(cx, cy) : cell_addr(px, py);

  // Transaction registers.
  logic              kind_r;
  logic [TYPE_W-1:0] seed_r;
  logic [DIR_W-1:0]  dir_r;
  logic              in_grid_r;
  logic [X_W-1:0]    cur_x_r;
  logic [Y_W-1:0]    cur_y_r;
  logic              cur_par_r;
  logic              done_r;
  logic [POS_W-1:0]  echo_x_r, echo_y_r;
  logic [ADDR_W-1:0] cur_addr_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r     <= in_kind;
      seed_r     <= in_seed_type;
      dir_r      <= in_direction;
      in_grid_r  <= in_grid;
      cur_x_r    <= cx;
      cur_y_r    <= cy;
      cur_par_r  <= par;
      done_r     <= (in_kind == KIND_VISIT) && grid_end;
      echo_x_r   <= (in_kind == KIND_VISIT) ? POS_W'(cx) : in_pos_x;
      echo_y_r   <= (in_kind == KIND_VISIT) ? POS_W'(cy) : in_pos_y;
      cur_addr_r <= start_addr;
    end
  end

  // Scan position moves on at the start of every visit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_x_r <= '0;
      scan_y_r <= '0;
      parity_r <= 1'b0;
    end else if (cmd.start && in_kind == KIND_VISIT) begin
      scan_x_r <= nscan_x;
      scan_y_r <= nscan_y;
      parity_r <= par ^ grid_end;
    end
  end

  // Clearing pass counter.
  logic [ADDR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  // Grid memory with registered read data.
  logic [ENTRY_W-1:0] grid_mem [DEPTH];
  logic [ENTRY_W-1:0] rd_q_r;
  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data;

  // Cell phase: decisions on the entry just read.
  logic [TYPE_W-1:0] e_type;
  logic              locked;
  logic              need_spread;
  logic              do_place;

  assign e_type      = rd_q_r[TYPE_W-1:0];
  assign locked      = rd_q_r[ENT_LOCK] && (rd_q_r[ENT_STAMP] == cur_par_r);
  assign need_spread = (kind_r == KIND_VISIT) && (e_type != TYPE_EMPTY) && !locked;
  assign do_place    = in_grid_r && (seed_r != TYPE_EMPTY) && can_take(seed_r, e_type);

  // Wrapped neighbour of the visited cell.
  logic [XC_W-1:0]   xp1_full;
  logic [YC_W-1:0]   yp1_full;
  logic [X_W-1:0]    xm1, xp1, nb_x;
  logic [Y_W-1:0]    ym1, yp1, nb_y;
  logic [ADDR_W-1:0] nb_addr;

  always_comb begin
    xp1_full = XC_W'(cur_x_r) + XC_W'(1);
    yp1_full = YC_W'(cur_y_r) + YC_W'(1);
    xm1 = (cur_x_r == '0) ? X_W'(w - XC_W'(1)) : cur_x_r - X_W'(1);
    ym1 = (cur_y_r == '0) ? Y_W'(h - YC_W'(1)) : cur_y_r - Y_W'(1);
    xp1 = (xp1_full >= w) ? '0 : xp1_full[X_W-1:0];
    yp1 = (yp1_full >= h) ? '0 : yp1_full[Y_W-1:0];
    nb_x = cur_x_r;
    nb_y = cur_y_r;
    unique case (dir_r)
      DIR_UP:    nb_y = ym1;
      DIR_DOWN:  nb_y = yp1;
      DIR_LEFT:  nb_x = xm1;
      DIR_RIGHT: nb_x = xp1;
    endcase
    nb_addr = cell_addr(nb_x, nb_y);
  end

  // Spreading type and neighbour address kept for the neighbour phase.
  logic [TYPE_W-1:0] t_r;
  logic [ADDR_W-1:0] nb_addr_r;
  logic              spread_win;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      t_r       <= e_type;
      nb_addr_r <= nb_addr;
    end
  end

  assign spread_win = can_take(t_r, rd_q_r[TYPE_W-1:0]);

  // Memory port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_addr_r;
    wr_data = '0;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
    end else if (cmd.eval) begin
      if (kind_r == KIND_VISIT) begin
        // The visited cell is written back with its lock dropped.
        wr_en   = 1'b1;
        wr_data = ENTRY_W'(e_type);
      end else begin
        // Placement keeps the lock bits of the cell.
        wr_en   = do_place;
        wr_data = {rd_q_r[ENT_STAMP:ENT_LOCK], seed_r};
      end
    end else if (cmd.spread) begin
      wr_en   = spread_win;
      wr_addr = nb_addr_r;
      wr_data = {cur_par_r, 1'b1, t_r};
    end
    rd_en   = cmd.start || (cmd.eval && need_spread);
    rd_addr = cmd.start ? start_addr : nb_addr;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= grid_mem[rd_addr];
    end
  end

  // Result selection.
  logic [TYPE_W-1:0] res_type;
  logic              res_conq;

  always_comb begin
    if (cmd.spread) begin
      res_type = t_r;
      res_conq = spread_win;
    end else if (kind_r == KIND_VISIT) begin
      res_type = e_type;
      res_conq = 1'b0;
    end else begin
      res_type = !in_grid_r ? TYPE_EMPTY : (do_place ? seed_r : e_type);
      res_conq = do_place;
    end
  end

  // Result register.
  logic              out_valid_r;
  logic [POS_W-1:0]  out_x_r, out_y_r;
  logic [TYPE_W-1:0] out_type_r;
  logic              out_conq_r, out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_x_r    <= echo_x_r;
      out_y_r    <= echo_y_r;
      out_type_r <= res_type;
      out_conq_r <= res_conq;
      out_done_r <= done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_x     = out_x_r;
  assign out_cell_y     = out_y_r;
  assign out_cell_type  = out_type_r;
  assign out_conquered  = out_conq_r;
  assign out_sweep_done = out_done_r;

  // Status to the controller.
  assign stat.clr_last    = clr_cnt_r == ADDR_W'(DEPTH - 1);
  assign stat.need_spread = need_spread;
  assign stat.out_busy    = out_valid_r && !out_ready;

endmodule

[rtl/cdgs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cyclic dominance grid spread: port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module cdgs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [cdgs_pkg::POS_W-1:0]      out_cell_x,
  input logic [cdgs_pkg::POS_W-1:0]      out_cell_y,
  input logic [cdgs_pkg::TYPE_W-1:0]     out_cell_type,
  input logic                            out_conquered,
  input logic                            out_sweep_done
);
  import cdgs_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_cell_x, out_cell_y, out_cell_type, out_conquered, out_sweep_done}))
    else $error("result changed while stalled");

  // The grid is being cleared right after reset, so nothing is taken.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during clearing pass");

  // After a transaction is taken, the evaluate state holds in_ready low.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in consecutive cycles");

  // A conquest always leaves an occupied cell behind.
  a_conquest_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_conquered |-> out_cell_type != TYPE_EMPTY)
    else $error("conquest reported with an empty cell");

endmodule

bind cyclic_dominance_grid_spread cdgs_checker u_cdgs_checker (.*);

[test/cyclic_dominance_grid_spread_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cyclic dominance grid spread: testbench
// Runs a short scripted sequence of place and visit transactions, then random
// traffic over a range of grid sizes, including zero and oversized settings.
// Every result is checked against a predictor of the grid, its scan position
// and its sweep parity held inside the testbench, or against a typed script entry.
// ----------------------------------------------------------------------------
module cyclic_dominance_grid_spread_tb;
  import cdgs_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT  = 60000;
  localparam int LONG_HOLD       = 400;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int SCRIPT_LEN      = 26;
  localparam int REPORT_LIMIT    = 10;

  // Row kinds of the script, and where a row's expected result comes from.
  localparam logic ROW_ITEM   = 1'b0;
  localparam logic ROW_RESIZE = 1'b1;
  localparam logic BY_MODEL   = 1'b0;
  localparam logic BY_TABLE   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [TYPE_W-1:0] seed;
    logic [DIR_W-1:0]  dir;
  } grid_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cell_x;
    logic [POS_W-1:0]  cell_y;
    logic [TYPE_W-1:0] cell_type;
    logic              conquered;
    logic              sweep_done;
  } cell_report_t;

  typedef struct packed {
    logic              op;
    logic              source;
    logic              kind;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [TYPE_W-1:0] seed;
    logic [DIR_W-1:0]  dir;
    logic [CFG_W-1:0]  cols;
    logic [CFG_W-1:0]  rows;
    logic [TYPE_W-1:0] want_type;
    logic              want_conq;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic in_kind;
  logic [POS_W-1:0] in_pos_x;
  logic [POS_W-1:0] in_pos_y;
  logic [TYPE_W-1:0] in_seed_type;
  logic [DIR_W-1:0] in_direction;
  logic out_valid;
  logic out_ready;
  logic [POS_W-1:0] out_cell_x;
  logic [POS_W-1:0] out_cell_y;
  logic [TYPE_W-1:0] out_cell_type;
  logic out_conquered;
  logic out_sweep_done;

  // Predicted grid contents, scan position, sweep parity and registers.
  logic [ENTRY_W-1:0] grid_mem [DEPTH];
  int unsigned scan_col;
  int unsigned scan_row;
  bit sweep_odd;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  cell_report_t cell_reports_due [$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int places_sent = 0;
  int visits_sent = 0;
  int resize_count = 0;
  int conquests_seen = 0;
  int sweeps_seen = 0;
  bit long_hold_req = 1'b0;

  // Cols and rows per random phase: zero and oversized values among them.
  logic [CFG_W-1:0] phase_cols [PHASES] = '{8'd6, 8'd1, 8'd9, 8'd2, 8'd128,
                                            8'd4, 8'd0, 8'd255, 8'd12, 8'd3};
  logic [CFG_W-1:0] phase_rows [PHASES] = '{8'd5, 8'd7, 8'd1, 8'd2, 8'd128,
                                            8'd3, 8'd6, 8'd4, 8'd10, 8'd255};

  // Directed script; typed results are those that follow from the rules at sight.
  script_row_t script [SCRIPT_LEN] = '{
    // Conquest cycle on one cell, starting from the reset size of 100 x 100.
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd0, 7'd0, TYPE_NORMAL, DIR_UP, 8'd0, 8'd0,
      TYPE_NORMAL, 1'b1},
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd0, 7'd0, TYPE_TOXIC, DIR_UP, 8'd0, 8'd0,
      TYPE_TOXIC, 1'b1},
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd0, 7'd0, TYPE_NORMAL, DIR_UP, 8'd0, 8'd0,
      TYPE_TOXIC, 1'b0},
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd0, 7'd0, TYPE_IMMUNE, DIR_UP, 8'd0, 8'd0,
      TYPE_IMMUNE, 1'b1},
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd0, 7'd0, TYPE_EMPTY, DIR_UP, 8'd0, 8'd0,
      TYPE_IMMUNE, 1'b0},
    // Last cell inside the grid, then positions just outside and at the top.
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd99, 7'd99, TYPE_TOXIC, DIR_UP, 8'd0, 8'd0,
      TYPE_TOXIC, 1'b1},
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd100, 7'd5, TYPE_NORMAL, DIR_UP, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd5, 7'd100, TYPE_IMMUNE, DIR_UP, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd127, 7'd127, TYPE_TOXIC, DIR_UP, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    // Neighbours for the first visits, one of them across the top edge.
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd1, 7'd0, TYPE_NORMAL, DIR_UP, 8'd0, 8'd0,
      TYPE_NORMAL, 1'b1},
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd2, 7'd0, TYPE_TOXIC, DIR_UP, 8'd0, 8'd0,
      TYPE_TOXIC, 1'b1},
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd2, 7'd99, TYPE_NORMAL, DIR_UP, 8'd0, 8'd0,
      TYPE_NORMAL, 1'b1},
    '{ROW_ITEM, BY_MODEL, KIND_VISIT, 7'd127, 7'd127, TYPE_TOXIC, DIR_RIGHT, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    '{ROW_ITEM, BY_MODEL, KIND_VISIT, 7'd64, 7'd1, TYPE_EMPTY, DIR_LEFT, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    '{ROW_ITEM, BY_MODEL, KIND_VISIT, 7'd0, 7'd0, TYPE_IMMUNE, DIR_UP, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    '{ROW_ITEM, BY_MODEL, KIND_VISIT, 7'd3, 7'd90, TYPE_NORMAL, DIR_DOWN, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    // Zero size reads as a single cell: the scan restarts and spreads meet themselves.
    '{ROW_RESIZE, BY_MODEL, KIND_PLACE, 7'd0, 7'd0, TYPE_EMPTY, DIR_UP, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd1, 7'd0, TYPE_TOXIC, DIR_UP, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    '{ROW_ITEM, BY_MODEL, KIND_VISIT, 7'd0, 7'd0, TYPE_EMPTY, DIR_UP, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    '{ROW_ITEM, BY_MODEL, KIND_VISIT, 7'd0, 7'd0, TYPE_EMPTY, DIR_RIGHT, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    // Oversized settings clamp to the full store.
    '{ROW_RESIZE, BY_MODEL, KIND_PLACE, 7'd0, 7'd0, TYPE_EMPTY, DIR_UP, 8'd255, 8'd200,
      TYPE_EMPTY, 1'b0},
    '{ROW_ITEM, BY_TABLE, KIND_PLACE, 7'd127, 7'd127, TYPE_TOXIC, DIR_UP, 8'd0, 8'd0,
      TYPE_TOXIC, 1'b1},
    '{ROW_ITEM, BY_MODEL, KIND_VISIT, 7'd0, 7'd0, TYPE_EMPTY, DIR_LEFT, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    // A single row: vertical spreads wrap onto the cell itself.
    '{ROW_RESIZE, BY_MODEL, KIND_PLACE, 7'd0, 7'd0, TYPE_EMPTY, DIR_UP, 8'd2, 8'd1,
      TYPE_EMPTY, 1'b0},
    '{ROW_ITEM, BY_MODEL, KIND_VISIT, 7'd0, 7'd0, TYPE_EMPTY, DIR_DOWN, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0},
    '{ROW_ITEM, BY_MODEL, KIND_VISIT, 7'd0, 7'd0, TYPE_EMPTY, DIR_RIGHT, 8'd0, 8'd0,
      TYPE_EMPTY, 1'b0}
  };

  cyclic_dominance_grid_spread u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_seed_type   (in_seed_type),
    .in_direction   (in_direction),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_x     (out_cell_x),
    .out_cell_y     (out_cell_y),
    .out_cell_type  (out_cell_type),
    .out_conquered  (out_conquered),
    .out_sweep_done (out_sweep_done)
  );

  always #(CLK_HALF) clk = ~clk;

  // Effective grid dimension: zero reads as one, anything past the store as its size.
  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned limit);
    if (v == '0) begin
      return 1;
    end
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  // Cyclic dominance: each type has exactly one prey, and empty cells fall to anyone.
  function automatic bit takes_over(logic [TYPE_W-1:0] attacker,
                                    logic [TYPE_W-1:0] defender);
    logic [TYPE_W-1:0] prey;
    case (attacker)
      TYPE_TOXIC: begin
        prey = TYPE_NORMAL;
      end
      TYPE_IMMUNE: begin
        prey = TYPE_TOXIC;
      end
      TYPE_NORMAL: begin
        prey = TYPE_IMMUNE;
      end
      default: begin
        prey = TYPE_EMPTY;
      end
    endcase
    return (defender == TYPE_EMPTY) || (attacker != TYPE_EMPTY && defender == prey);
  endfunction

  // Applies one transaction to the predicted grid and returns the cell it reports.
  function automatic cell_report_t advance_grid(grid_item_t s);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    int unsigned ncol;
    int unsigned nrow;
    int unsigned here;
    int unsigned there;
    logic [TYPE_W-1:0] own;
    logic [ENTRY_W-1:0] won;
    bit held;
    cell_report_t r;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    r = '0;
    if (s.kind == KIND_PLACE) begin
      r.cell_x = s.pos_x;
      r.cell_y = s.pos_y;
      if (s.pos_x < w && s.pos_y < h) begin
        here = s.pos_y * MAX_WIDTH + s.pos_x;
        own = grid_mem[here][TYPE_W-1:0];
        // A placement leaves the lock bits alone.
        if (s.seed != TYPE_EMPTY && takes_over(s.seed, own)) begin
          grid_mem[here][TYPE_W-1:0] = s.seed;
          own = s.seed;
          r.conquered = 1'b1;
        end
        r.cell_type = own;
      end
    end else begin
      // Pull a scan position left outside a shrunken grid back inside.
      col = scan_col;
      row = scan_row;
      if (col >= w) begin
        col = 0;
        row = row + 1;
      end
      if (row >= h) begin
        col = 0;
        row = 0;
        sweep_odd = ~sweep_odd;
      end
      here = row * MAX_WIDTH + col;
      own = grid_mem[here][TYPE_W-1:0];
      held = grid_mem[here][ENT_LOCK] && (grid_mem[here][ENT_STAMP] == sweep_odd);
      grid_mem[here] = ENTRY_W'(own);
      // An occupied, unlocked cell tries to take its wrapped neighbour.
      if (own != TYPE_EMPTY && !held) begin
        ncol = col;
        nrow = row;
        case (s.dir)
          DIR_UP: begin
            nrow = (row == 0) ? h - 1 : row - 1;
          end
          DIR_DOWN: begin
            nrow = (row + 1 >= h) ? 0 : row + 1;
          end
          DIR_LEFT: begin
            ncol = (col == 0) ? w - 1 : col - 1;
          end
          default: begin
            ncol = (col + 1 >= w) ? 0 : col + 1;
          end
        endcase
        there = nrow * MAX_WIDTH + ncol;
        if (takes_over(own, grid_mem[there][TYPE_W-1:0])) begin
          won = '0;
          won[TYPE_W-1:0] = own;
          won[ENT_LOCK] = 1'b1;
          won[ENT_STAMP] = sweep_odd;
          grid_mem[there] = won;
          r.conquered = 1'b1;
        end
      end
      r.cell_x = POS_W'(col);
      r.cell_y = POS_W'(row);
      r.cell_type = grid_mem[here][TYPE_W-1:0];
      // Step to the next cell in raster order; wrapping the last row ends a sweep.
      col = col + 1;
      if (col >= w) begin
        col = 0;
        row = row + 1;
        if (row >= h) begin
          row = 0;
          sweep_odd = ~sweep_odd;
          r.sweep_done = 1'b1;
        end
      end
      scan_col = col;
      scan_row = row;
    end
    return r;
  endfunction

  // Random transaction: mostly visits, with placements mostly inside the grid.
  function automatic grid_item_t random_item();
    grid_item_t s;
    int unsigned w;
    int unsigned h;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    s.kind = ($urandom_range(0, 9) < 3) ? KIND_PLACE : KIND_VISIT;
    s.dir = DIR_W'($urandom);
    s.seed = ($urandom_range(0, 15) == 0) ? TYPE_EMPTY : TYPE_W'($urandom_range(1, 3));
    if (s.kind == KIND_PLACE && $urandom_range(0, 7) != 0) begin
      s.pos_x = POS_W'($urandom_range(0, w - 1));
      s.pos_y = POS_W'($urandom_range(0, h - 1));
    end else begin
      s.pos_x = POS_W'($urandom);
      s.pos_y = POS_W'($urandom);
    end
    return s;
  endfunction

  // Offers one transaction after any burst gap and records its expected result.
  task automatic offer_item(input grid_item_t s, input logic source,
                            input cell_report_t typed);
    int gap;
    cell_report_t due;
    cell_report_t queued;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left = burst_left - 1;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_kind      <= s.kind;
    in_pos_x     <= s.pos_x;
    in_pos_y     <= s.pos_y;
    in_seed_type <= s.seed;
    in_direction <= s.dir;
    @(posedge clk);
    while (in_ready !== 1'b1) begin
      @(posedge clk);
    end
    due = advance_grid(s);
    queued = (source == BY_TABLE) ? typed : due;
    cell_reports_due = {cell_reports_due, queued};
    if (s.kind == KIND_PLACE) begin
      places_sent++;
    end else begin
      visits_sent++;
    end
  endtask

  // One register write transaction; the caller lowers cfg_valid afterwards.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) begin
      @(posedge clk);
    end
    if (idx == REG_GRID_WIDTH) begin
      width_reg = value;
    end else begin
      height_reg = value;
    end
  endtask

  // Lets the block drain, then writes a new grid size.
  task automatic resize_grid(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    @(negedge clk);
    in_valid <= 1'b0;
    while (cell_reports_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(REG_GRID_WIDTH, cols);
    write_register(REG_GRID_HEIGHT, rows);
    @(negedge clk);
    cfg_valid <= 1'b0;
    resize_count++;
  endtask

  // Result consumer: stretches of varying readiness, plus one long hold on request.
  initial begin : result_sink
    int stretch_left;
    int ready_odds;
    stretch_left = 0;
    ready_odds = 100;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: ready_odds = 100;
            1: ready_odds = 70;
            2: ready_odds = 40;
            default: ready_odds = 15;
          endcase
        end
        stretch_left = stretch_left - 1;
        out_ready <= ($urandom_range(1, 100) <= ready_odds);
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    cell_report_t seen;
    cell_report_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      seen = '{out_cell_x, out_cell_y, out_cell_type, out_conquered, out_sweep_done};
      if (seen.conquered) begin
        conquests_seen++;
      end
      if (seen.sweep_done) begin
        sweeps_seen++;
      end
      if (cell_reports_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("%0t: unexpected result x=%0d y=%0d type=%0d conq=%0b done=%0b",
                   $realtime, seen.cell_x, seen.cell_y, seen.cell_type,
                   seen.conquered, seen.sweep_done);
        end
      end else begin
        want = cell_reports_due.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch expected x=%0d y=%0d type=%0d conq=%0b done=%0b",
                     $realtime, want.cell_x, want.cell_y, want.cell_type,
                     want.conquered, want.sweep_done);
            $display("%0t:          actual   x=%0d y=%0d type=%0d conq=%0b done=%0b",
                     $realtime, seen.cell_x, seen.cell_y, seen.cell_type,
                     seen.conquered, seen.sweep_done);
          end
        end
      end
    end
  end

  // Ends the run when no transaction moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) ||
        (out_valid === 1'b1 && out_ready === 1'b1) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed script, random phases, drain.
  initial begin : stimulus
    int i;
    int p;
    int n;
    grid_item_t s;
    cell_report_t typed;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_GRID_WIDTH;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_kind      = KIND_PLACE;
    in_pos_x     = '0;
    in_pos_y     = '0;
    in_seed_type = TYPE_EMPTY;
    in_direction = DIR_UP;
    out_ready    = 1'b0;
    for (i = 0; i < DEPTH; i++) begin
      grid_mem[i] = '0;
    end
    scan_col   = 0;
    scan_row   = 0;
    sweep_odd  = 1'b0;
    width_reg  = GRID_SIZE_RESET;
    height_reg = GRID_SIZE_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed script; the block's clearing pass holds off the first transaction.
    for (i = 0; i < SCRIPT_LEN; i++) begin
      if (script[i].op == ROW_RESIZE) begin
        resize_grid(script[i].cols, script[i].rows);
      end else begin
        s = '{script[i].kind, script[i].pos_x, script[i].pos_y, script[i].seed,
              script[i].dir};
        typed = '{script[i].pos_x, script[i].pos_y, script[i].want_type,
                  script[i].want_conq, 1'b0};
        offer_item(s, script[i].source, typed);
      end
    end

    // Random phases, one grid size each; the third one opens with a long stall.
    for (p = 0; p < PHASES; p++) begin
      resize_grid(phase_cols[p], phase_rows[p]);
      if (p == 2) begin
        long_hold_req = 1'b1;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        offer_item(random_item(), BY_MODEL, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (cell_reports_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d place and %0d visit transactions over %0d grid sizes.",
             places_sent, visits_sent, resize_count + 1);
    $display("Saw %0d conquests and %0d completed sweeps; %0d mismatches.",
             conquests_seen, sweeps_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cdgs_pkg.sv
rtl/cdgs_ctrl.sv
rtl/cdgs_dp.sv
rtl/cyclic_dominance_grid_spread.sv
rtl/cdgs_checker.sv
test/cyclic_dominance_grid_spread_tb.sv
